// ----- src/gps_pkg.sv -----
// Shared types and constants of the gather packet segmenter.
package gps_pkg;

    localparam int LEN_W   = 13;
    localparam int HDR_W   = 7;
    localparam int IDX_W   = 1;

    localparam logic [LEN_W-1:0] SEG_HI = LEN_W'(4096);
    localparam logic [LEN_W-1:0] PKT_LO = LEN_W'(128);
    localparam logic [HDR_W-1:0] HDR_HI = HDR_W'(64);

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_PACKET_SIZE = 1'b0;
    localparam logic [IDX_W-1:0] REG_HEADER      = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } gps_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic emit;
        logic last;
    } gps_sts_t;

    // One chunk descriptor
    typedef struct packed {
        logic [LEN_W-1:0] chunk_offset;
        logic [LEN_W-1:0] chunk_len;
        logic             chunk_zero_fill;
        logic             after_header;
        logic             packet_done;
        logic [LEN_W-1:0] packet_total;
        logic             message_done;
        logic             run_last;
    } gps_chunk_t;

endpackage

// ----- src/gps_seg_if.sv -----
// Segment request channel.
interface gps_seg_if;
    logic                       valid;
    logic                       ready;
    logic [gps_pkg::LEN_W-1:0]  seg_len;
    logic                       seg_has_data;
    logic                       seg_is_final;

    modport source (output valid, output seg_len, output seg_has_data,
                    output seg_is_final, input ready);
    modport sink   (input valid, input seg_len, input seg_has_data,
                    input seg_is_final, output ready);
endinterface

// ----- src/gps_chunk_if.sv -----
// Chunk descriptor request channel.
interface gps_chunk_if;
    logic                       valid;
    logic                       ready;
    logic [gps_pkg::LEN_W-1:0]  chunk_offset;
    logic [gps_pkg::LEN_W-1:0]  chunk_len;
    logic                       chunk_zero_fill;
    logic                       after_header;
    logic                       packet_done;
    logic [gps_pkg::LEN_W-1:0]  packet_total;
    logic                       message_done;
    logic                       run_last;

    modport source (output valid, output chunk_offset, output chunk_len,
                    output chunk_zero_fill, output after_header, output packet_done,
                    output packet_total, output message_done, output run_last,
                    input ready);
    modport sink   (input valid, input chunk_offset, input chunk_len,
                    input chunk_zero_fill, input after_header, input packet_done,
                    input packet_total, input message_done, input run_last,
                    output ready);
endinterface

// ----- src/gps_cfg_if.sv -----
// Configuration write channel.
interface gps_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [gps_pkg::IDX_W-1:0]  index;
    logic [gps_pkg::LEN_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/gather_packet_segmenter_core.sv -----
// Top level of the gather packet segmenter.
//
//  channel  direction  handshake       payload
//  seg      in         valid / ready   seg_len, seg_has_data, seg_is_final
//  chunk    out        valid / ready   chunk descriptor fields
//  cfg      in         valid / ready   index, data (always ready)
//
// A segment request is taken while idle, then one chunk is produced per
// cycle (1 to 33 chunks); an empty non-final segment gives no chunk. The
// output register stalls the step while a chunk waits on chunk.ready.
// Reset leaves 2048-byte packets, 16-byte header, an empty packet and the
// header due.
module gather_packet_segmenter_core #(
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    gps_seg_if.sink      seg,
    gps_chunk_if.source  chunk,
    gps_cfg_if.sink      cfg
);

    // Upper clamp of the packet size
    localparam int PKT_HI = (MAX_PACKET_BYTES < 4096) ? MAX_PACKET_BYTES : 4096;

    gps_pkg::gps_cmd_t   cmd;
    gps_pkg::gps_sts_t   sts;
    gps_pkg::gps_chunk_t chunk_q;

    // Configuration is always taken; the user must write it only while idle; the block does not enforce this
    assign cfg.ready = 1'b1;

    gps_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .seg_valid   (seg.valid),
        .seg_ready   (seg.ready),
        .chunk_valid (chunk.valid),
        .chunk_ready (chunk.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    gps_dpath #(
        .PKT_HI (PKT_HI)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .seg_len      (seg.seg_len),
        .seg_has_data (seg.seg_has_data),
        .seg_is_final (seg.seg_is_final),
        .cmd          (cmd),
        .sts          (sts),
        .chunk        (chunk_q)
    );

    // Drive the descriptor fields from the output register
    assign chunk.chunk_offset    = chunk_q.chunk_offset;
    assign chunk.chunk_len       = chunk_q.chunk_len;
    assign chunk.chunk_zero_fill = chunk_q.chunk_zero_fill;
    assign chunk.after_header    = chunk_q.after_header;
    assign chunk.packet_done     = chunk_q.packet_done;
    assign chunk.packet_total    = chunk_q.packet_total;
    assign chunk.message_done    = chunk_q.message_done;
    assign chunk.run_last        = chunk_q.run_last;

`ifndef NO_ASSERTIONS
    // A taken segment always moves the controller out of idle
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seg.valid && seg.ready |=> !seg.ready)
        else $error("segment taken without leaving idle");

    // The message end is always the last chunk of its segment
    a_md_last: assert property (@(posedge clk) disable iff (!rst_n)
        chunk.valid && chunk.message_done |-> chunk.run_last)
        else $error("message end not on last chunk of segment");

    // Zero fill is never flagged on an empty chunk
    a_zf_len: assert property (@(posedge clk) disable iff (!rst_n)
        chunk.valid && chunk.chunk_len == '0 |-> !chunk.chunk_zero_fill)
        else $error("zero fill on empty chunk");

    // An open packet carries a non-zero fill unless the message just ended
    a_open_fill: assert property (@(posedge clk) disable iff (!rst_n)
        chunk.valid && !chunk.packet_done |->
            chunk.packet_total != '0 || chunk.message_done)
        else $error("open packet reported with zero fill");
`endif

endmodule

// ----- src/gps_ctrl.sv -----
// Sequencing controller: accepts segments and paces chunk generation.
module gps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seg_valid,
    output logic              seg_ready,
    output logic              chunk_valid,
    input  logic              chunk_ready,
    input  gps_pkg::gps_sts_t sts,
    output gps_pkg::gps_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign seg_ready   = (state_reg == ST_IDLE);
    assign chunk_valid = out_valid_reg;
    assign out_free    = !out_valid_reg || chunk_ready;

    always_comb
    begin
        cmd.load   = seg_valid && seg_ready;
        cmd.step   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = out_free;
                if (out_free && sts.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !chunk_ready) || (cmd.step && sts.emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/gps_dpath.sv -----
// Segmentation datapath: configuration, packet state and chunk arithmetic.
module gps_dpath #(
    parameter int PKT_HI = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [gps_pkg::IDX_W-1:0]  cfg_index,
    input  logic [gps_pkg::LEN_W-1:0]  cfg_data,
    input  logic [gps_pkg::LEN_W-1:0]  seg_len,
    input  logic                       seg_has_data,
    input  logic                       seg_is_final,
    input  gps_pkg::gps_cmd_t          cmd,
    output gps_pkg::gps_sts_t          sts,
    output gps_pkg::gps_chunk_t        chunk
);

    localparam logic [gps_pkg::LEN_W-1:0] EFF_HI = gps_pkg::LEN_W'(PKT_HI);

    logic [gps_pkg::LEN_W-1:0] pkt_size_reg;
    logic [gps_pkg::HDR_W-1:0] hdr_size_reg;
    logic [gps_pkg::LEN_W-1:0] fill_reg, fill_next;
    logic                      hdr_pend_reg, hdr_pend_next;
    logic [gps_pkg::LEN_W-1:0] len_reg;
    logic [gps_pkg::LEN_W-1:0] pos_reg, pos_next;
    logic                      zf_reg;
    logic                      fin_reg;
    gps_pkg::gps_chunk_t       chunk_reg, res;

    logic [gps_pkg::LEN_W-1:0] eff, hb, base, room, remain, take, nf, pos_new;
    logic                      at_end, full, md, pd;

    always_comb
    begin
        if (pkt_size_reg < gps_pkg::PKT_LO)
            eff = gps_pkg::PKT_LO;
        else if (pkt_size_reg > EFF_HI)
            eff = EFF_HI;
        else
            eff = pkt_size_reg;
        hb = (hdr_size_reg > gps_pkg::HDR_HI) ? gps_pkg::LEN_W'(gps_pkg::HDR_HI)
                                               : gps_pkg::LEN_W'(hdr_size_reg);
    end

    always_comb
    begin
        base    = hdr_pend_reg ? hb : fill_reg;
        room    = eff - base;
        remain  = len_reg - pos_reg;
        take    = (room < remain) ? room : remain;
        nf      = base + take;
        pos_new = pos_reg + take;
        at_end  = (pos_new == len_reg);
        full    = (nf == eff);
        md      = at_end && fin_reg;
        pd      = full || md;

        res           = '0;
        sts.emit      = 1'b1;
        sts.last      = 1'b1;
        fill_next     = fill_reg;
        hdr_pend_next = hdr_pend_reg;
        pos_next      = pos_reg;

        if (len_reg == '0)
        begin
            // empty segment: close out the message when final
            sts.emit         = fin_reg;
            res.after_header = hdr_pend_reg;
            res.packet_done  = hdr_pend_reg || (fill_reg != '0);
            res.packet_total = hdr_pend_reg ? hb : fill_reg;
            res.message_done = 1'b1;
            res.run_last     = 1'b1;
            if (fin_reg)
            begin
                fill_next     = '0;
                hdr_pend_next = 1'b1;
            end
        end
        else if (base >= eff)
        begin
            // packet over-full after a size change: flush it first
            sts.last         = 1'b0;
            res.chunk_offset = pos_reg;
            res.packet_done  = 1'b1;
            res.packet_total = base;
            fill_next        = '0;
        end
        else
        begin
            sts.last            = at_end;
            res.chunk_offset    = pos_reg;
            res.chunk_len       = take;
            res.chunk_zero_fill = zf_reg;
            res.after_header    = hdr_pend_reg;
            res.packet_done     = pd;
            res.packet_total    = nf;
            res.message_done    = md;
            res.run_last        = at_end;
            hdr_pend_next       = md;
            fill_next           = pd ? '0 : nf;
            pos_next            = pos_new;
        end
    end

    assign chunk = chunk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_size_reg <= gps_pkg::LEN_W'(2048);
            hdr_size_reg <= gps_pkg::HDR_W'(16);
            fill_reg     <= '0;
            hdr_pend_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we && cfg_index == gps_pkg::REG_PACKET_SIZE)
                pkt_size_reg <= cfg_data;
            if (cfg_we && cfg_index == gps_pkg::REG_HEADER)
                hdr_size_reg <= cfg_data[gps_pkg::HDR_W-1:0];
            if (cmd.step)
            begin
                fill_reg     <= fill_next;
                hdr_pend_reg <= hdr_pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg <= (seg_len > gps_pkg::SEG_HI) ? gps_pkg::SEG_HI : seg_len;
            zf_reg  <= !seg_has_data;
            fin_reg <= seg_is_final;
            pos_reg <= '0;
        end
        else if (cmd.step)
        begin
            pos_reg <= pos_next;
        end
        if (cmd.step && sts.emit)
            chunk_reg <= res;
    end

endmodule
